/* rtl/core/csa_pkg.sv */
`timescale 1ns / 1ps

package csa_pkg;

  localparam int unsigned SlotsDef     = 64;
  localparam int unsigned OwnerBitsDef = 8;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_BUDDY = 2'd3
  } pol_e;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_IDX_POLICY = 1'b0,
    CFG_IDX_SLOTS  = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] owner_id;
    logic [6:0] request_size;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [5:0] start_slot;
    logic [6:0] slot_count;
  } out_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic release_op;
    pol_e pol;
  } scan_ctl_t;

endpackage

/* rtl/core/contiguous_slot_allocator_core.sv */
`timescale 1ns / 1ps
// Allocate: one pass through the rotating tag chain (scan), a decision state, then on
// success a second pass (write) to tag the run, then the response state.
// Release and failed allocate skip the write pass; an invalid request skips to response.
// One transaction at a time; the slot chain rotates one cell per cycle in both passes.
// Reset clears every tag, the next-fit start and the control registers at once.
module contiguous_slot_allocator_core #(
  parameter int unsigned Slots     = csa_pkg::SlotsDef,
  parameter int unsigned OwnerBits = csa_pkg::OwnerBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  csa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output csa_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [6:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots + 1);

  csa_pkg::state_e state_q, state_d;
  csa_pkg::pol_e   pol_q;
  logic [6:0]      slots_cfg_q;
  logic [IW-1:0]   nfs_q, idx_q, at_q;
  logic            kind_q;
  logic [OwnerBits-1:0] owner_q;
  logic [CW-1:0]   n_q, blk_q, blk_c, total_c;
  csa_pkg::out_t   res_q, out_q;
  logic            out_valid_q;

  logic [OwnerBits-1:0] tags [Slots];
  logic [OwnerBits-1:0] head_new, owner_c;
  logic            shift, accept, last, bad, found;
  logic [IW-1:0]   at_s;
  logic [CW-1:0]   cnt_s, ic;
  csa_pkg::scan_ctl_t ctl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == csa_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign last        = (idx_q == IW'(Slots - 1));
  assign ic          = CW'(idx_q);
  assign owner_c     = OwnerBits'(in_data_i.owner_id);
  assign total_c     = (32'(slots_cfg_q) > 32'(Slots)) ? CW'(Slots) : CW'(slots_cfg_q);
  assign shift       = (state_q == csa_pkg::ST_SCAN) || (state_q == csa_pkg::ST_WRITE);
  assign bad = (in_data_i.kind == csa_pkg::KIND_ALLOC) &&
               ((in_data_i.request_size == '0) ||
                (32'(in_data_i.request_size) > 32'(total_c)));

  always_comb begin
    blk_c = total_c;
    for (int k = 0; k < IW; k++) begin
      if ((blk_c >> 1) >= CW'(in_data_i.request_size)) begin
        blk_c = blk_c >> 1;
      end
    end
  end

  always_comb begin
    head_new = tags[0];
    if (state_q == csa_pkg::ST_SCAN && kind_q == csa_pkg::KIND_RELEASE &&
        ic < total_c && tags[0] == owner_q) begin
      head_new = '0;
    end else if (state_q == csa_pkg::ST_WRITE && idx_q >= at_q &&
                 ic < CW'(at_q) + n_q) begin
      head_new = owner_q;
    end
  end

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    csa_cell #(.OwnerBits(OwnerBits)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .tag_i  ((g == Slots - 1) ? head_new : tags[(g + 1) % Slots]),
      .tag_o  (tags[g])
    );
  end

  assign ctl.clear      = accept;
  assign ctl.step       = (state_q == csa_pkg::ST_SCAN);
  assign ctl.release_op = kind_q;
  assign ctl.pol        = pol_q;

  csa_scan #(.Slots(Slots), .OwnerBits(OwnerBits)) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .head_i (tags[0]),
    .owner_i(owner_q),
    .idx_i  (idx_q),
    .total_i(total_c),
    .n_i    (n_q),
    .lo_i   ((pol_q == csa_pkg::POL_NEXT) ? nfs_q : '0),
    .blk_i  (blk_q),
    .found_o(found),
    .at_o   (at_s),
    .count_o(cnt_s)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      csa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (bad || owner_c == '0) ? csa_pkg::ST_RESP : csa_pkg::ST_SCAN;
        end
      end
      csa_pkg::ST_SCAN: begin
        if (last) begin
          state_d = csa_pkg::ST_DECIDE;
        end
      end
      csa_pkg::ST_DECIDE: begin
        state_d = (found && kind_q == csa_pkg::KIND_ALLOC) ? csa_pkg::ST_WRITE
                                                            : csa_pkg::ST_RESP;
      end
      csa_pkg::ST_WRITE: begin
        if (last) begin
          state_d = csa_pkg::ST_RESP;
        end
      end
      csa_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = csa_pkg::ST_IDLE;
        end
      end
      default: state_d = csa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csa_pkg::ST_IDLE;
      pol_q       <= csa_pkg::POL_FIRST;
      slots_cfg_q <= 7'd64;
      nfs_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          csa_pkg::CFG_IDX_POLICY: pol_q <= csa_pkg::pol_e'(cfg_data_i[1:0]);
          csa_pkg::CFG_IDX_SLOTS:  slots_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (shift) begin
        idx_q <= last ? '0 : idx_q + IW'(1);
      end
      if (state_q == csa_pkg::ST_DECIDE && found && kind_q == csa_pkg::KIND_ALLOC &&
          pol_q == csa_pkg::POL_NEXT) begin
        nfs_q <= at_s;
      end
      if (state_q == csa_pkg::ST_RESP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_data_i.kind;
      owner_q <= owner_c;
      n_q     <= bad ? '0 : CW'(in_data_i.request_size);
      blk_q   <= blk_c;
      res_q   <= '{status: 1'b1, start_slot: '0, slot_count: '0};
    end
    if (state_q == csa_pkg::ST_DECIDE) begin
      at_q <= at_s;
      res_q.status     <= !found;
      res_q.start_slot <= found ? 6'(at_s) : '0;
      res_q.slot_count <= found ? 7'(cnt_s) : '0;
    end
    if (state_q == csa_pkg::ST_RESP && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

endmodule

/* rtl/core/csa_cell.sv */
`timescale 1ns / 1ps

module csa_cell #(
  parameter int unsigned OwnerBits = csa_pkg::OwnerBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [OwnerBits-1:0] tag_i,
  output logic [OwnerBits-1:0] tag_o
);

  logic [OwnerBits-1:0] tag_q, tag_d;

  assign tag_d = shift_i ? tag_i : tag_q;
  assign tag_o = tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

endmodule

/* rtl/core/csa_scan.sv */
`timescale 1ns / 1ps

module csa_scan #(
  parameter int unsigned Slots     = csa_pkg::SlotsDef,
  parameter int unsigned OwnerBits = csa_pkg::OwnerBitsDef,
  localparam int unsigned IW = $clog2(Slots),
  localparam int unsigned CW = $clog2(Slots + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csa_pkg::scan_ctl_t   ctl_i,
  input  logic [OwnerBits-1:0] head_i,
  input  logic [OwnerBits-1:0] owner_i,
  input  logic [IW-1:0]        idx_i,
  input  logic [CW-1:0]        total_i,
  input  logic [CW-1:0]        n_i,
  input  logic [IW-1:0]        lo_i,
  input  logic [CW-1:0]        blk_i,
  output logic                 found_o,
  output logic [IW-1:0]        at_o,
  output logic [CW-1:0]        count_o
);

  logic [CW-1:0] run0_q, run0_d, run1_q, run1_d;
  logic          f0_q, f0_d, f1_q, f1_d;
  logic [IW-1:0] a0_q, a0_d, a1_q, a1_d;
  logic [CW-1:0] hlen_q, hlen_d, blen_q, blen_d;
  logic [IW-1:0] hs_q, hs_d, bs_q, bs_d;
  logic          bf_q, bf_d;
  logic [CW-1:0] ublk_q, ublk_d;
  logic [IW-1:0] ustart_q, ustart_d;
  logic          ufree_q, ufree_d, uf_q, uf_d;
  logic [IW-1:0] ua_q, ua_d;
  logic          rf_q, rf_d;
  logic [IW-1:0] rs_q, rs_d;
  logic [CW-1:0] rc_q, rc_d;

  logic [CW-1:0] ic, clen, run0_n, run1_n;
  logic          freev, r0, r1, last, closeh, match;
  logic [IW-1:0] cstart, at_hit;
  logic          fsel;
  logic [IW-1:0] asel;

  always_comb begin
    ic     = CW'(idx_i);
    last   = (idx_i == IW'(Slots - 1));
    freev  = (head_i == '0) && (ic < total_i);
    match  = (head_i == owner_i) && (ic < total_i);
    r1     = (idx_i >= lo_i);
    r0     = !r1;
    run0_n = run0_q + CW'(1);
    run1_n = run1_q + CW'(1);
    at_hit = IW'(ic + CW'(1) - n_i);

    run0_d = (r0 && freev) ? run0_n : '0;
    run1_d = (r1 && freev) ? run1_n : '0;
    f0_d = f0_q;
    a0_d = a0_q;
    f1_d = f1_q;
    a1_d = a1_q;
    if (r0 && freev && run0_n >= n_i && !f0_q) begin
      f0_d = 1'b1;
      a0_d = at_hit;
    end
    if (r1 && freev && run1_n >= n_i && !f1_q) begin
      f1_d = 1'b1;
      a1_d = at_hit;
    end

    clen   = freev ? hlen_q + CW'(1) : hlen_q;
    cstart = (freev && hlen_q == '0) ? idx_i : hs_q;
    closeh = !freev || last;
    hlen_d = freev ? clen : '0;
    hs_d   = cstart;
    bf_d   = bf_q;
    blen_d = blen_q;
    bs_d   = bs_q;
    if (closeh && clen >= n_i && clen != '0 && (!bf_q || clen < blen_q)) begin
      bf_d   = 1'b1;
      blen_d = clen;
      bs_d   = cstart;
    end

    ufree_d  = ((ublk_q == '0) ? 1'b1 : ufree_q) && freev;
    ustart_d = (ublk_q == '0) ? idx_i : ustart_q;
    uf_d     = uf_q;
    ua_d     = ua_q;
    if (ublk_q == blk_i - CW'(1)) begin
      ublk_d = '0;
      if (ufree_d && !uf_q) begin
        uf_d = 1'b1;
        ua_d = ustart_d;
      end
    end else begin
      ublk_d = ublk_q + CW'(1);
    end

    rf_d = rf_q;
    rs_d = rs_q;
    rc_d = rc_q;
    if (match) begin
      rc_d = rc_q + CW'(1);
      if (!rf_q) begin
        rf_d = 1'b1;
        rs_d = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run0_q <= '0; run1_q <= '0; f0_q <= 1'b0; f1_q <= 1'b0;
      hlen_q <= '0; bf_q <= 1'b0; ublk_q <= '0; ufree_q <= 1'b0;
      uf_q <= 1'b0; rf_q <= 1'b0; rc_q <= '0;
    end else if (ctl_i.clear) begin
      run0_q <= '0; run1_q <= '0; f0_q <= 1'b0; f1_q <= 1'b0;
      hlen_q <= '0; bf_q <= 1'b0; ublk_q <= '0; ufree_q <= 1'b0;
      uf_q <= 1'b0; rf_q <= 1'b0; rc_q <= '0;
    end else if (ctl_i.step) begin
      run0_q <= run0_d; run1_q <= run1_d; f0_q <= f0_d; f1_q <= f1_d;
      hlen_q <= hlen_d; bf_q <= bf_d; ublk_q <= ublk_d; ufree_q <= ufree_d;
      uf_q <= uf_d; rf_q <= rf_d; rc_q <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      a0_q <= a0_d; a1_q <= a1_d; hs_q <= hs_d; blen_q <= blen_d;
      bs_q <= bs_d; ustart_q <= ustart_d; ua_q <= ua_d; rs_q <= rs_d;
    end
  end

  always_comb begin
    case (ctl_i.pol)
      csa_pkg::POL_FIRST,
      csa_pkg::POL_NEXT: begin
        fsel = f1_q || f0_q;
        asel = f1_q ? a1_q : a0_q;
      end
      csa_pkg::POL_BEST: begin
        fsel = bf_q;
        asel = bs_q;
      end
      csa_pkg::POL_BUDDY: begin
        fsel = uf_q;
        asel = ua_q;
      end
      default: begin
        fsel = 1'b0;
        asel = '0;
      end
    endcase
    found_o = ctl_i.release_op ? rf_q : fsel;
    at_o    = ctl_i.release_op ? rs_q : asel;
    count_o = ctl_i.release_op ? rc_q : n_i;
  end

endmodule

/* verif/contiguous_slot_allocator_core_checker.sv */
`timescale 1ns / 1ps

module contiguous_slot_allocator_core_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  csa_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  csa_pkg::out_t out_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic          cfg_index_i,
  input  logic [6:0]    cfg_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            result_count_o
);
  import csa_pkg::*;

  logic [7:0]    owner_tab [64];
  logic [5:0]    nf_start;
  pol_e          policy;
  logic [6:0]    region_reg;
  out_t          awaited_q [$];

  function automatic int region();
    return (region_reg > 7'd64) ? 64 : int'(region_reg);
  endfunction

  function automatic int free_run_from(int lo, int hi, int n);
    int run;
    run = 0;
    for (int i = lo; i < hi; i++) begin
      if (owner_tab[i] == 8'd0) begin
        run++;
        if (run >= n) return i + 1 - n;
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  function automatic int smallest_hole(int total, int n);
    int best, best_len, i, s;
    best = -1;
    best_len = 0;
    i = 0;
    while (i < total) begin
      if (owner_tab[i] != 8'd0) begin
        i++;
      end else begin
        s = i;
        while (i < total && owner_tab[i] == 8'd0) i++;
        if ((i - s) >= n && (best < 0 || (i - s) < best_len)) begin
          best = s;
          best_len = i - s;
        end
      end
    end
    return best;
  endfunction

  function automatic int buddy_block(int total, int n);
    int blk;
    bit ok;
    blk = total;
    while (blk / 2 >= n) blk = blk / 2;
    for (int b = 0; b + blk <= total; b += blk) begin
      ok = 1;
      for (int j = b; j < b + blk; j++) if (owner_tab[j] != 8'd0) ok = 0;
      if (ok) return b;
    end
    return -1;
  endfunction

  function automatic out_t allocate_or_release(in_t req);
    out_t r;
    int total, n, at, cnt, lim;
    bit found;
    total = region();
    n = int'(req.request_size);
    r = '0;
    r.status = 1'b1;
    if (kind_e'(req.kind) == KIND_ALLOC) begin
      at = -1;
      if (req.owner_id != 8'd0 && n != 0 && n <= total) begin
        case (policy)
          POL_FIRST: at = free_run_from(0, total, n);
          POL_NEXT: begin
            at = free_run_from(int'(nf_start), total, n);
            lim = (int'(nf_start) < total) ? int'(nf_start) : total;
            if (at < 0) at = free_run_from(0, lim, n);
            if (at >= 0) nf_start = at[5:0];
          end
          POL_BEST: at = smallest_hole(total, n);
          default: at = buddy_block(total, n);
        endcase
      end
      if (at >= 0) begin
        for (int i = at; i < at + n; i++) owner_tab[i] = req.owner_id;
        r.status = 1'b0;
        r.start_slot = at[5:0];
        r.slot_count = n[6:0];
      end
    end else if (req.owner_id != 8'd0) begin
      found = 0;
      cnt = 0;
      for (int i = 0; i < total; i++) begin
        if (owner_tab[i] == req.owner_id) begin
          if (!found) r.start_slot = i[5:0];
          found = 1;
          owner_tab[i] = 8'd0;
          cnt++;
        end
      end
      if (found) begin
        r.status = 1'b0;
        r.slot_count = cnt[6:0];
      end
    end
    return r;
  endfunction

  assign pending_o = awaited_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) owner_tab[i] = 8'd0;
      nf_start = '0;
      policy = POL_FIRST;
      region_reg = 7'd64;
      awaited_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %p", out_data_i);
        end else begin
          exp_r = awaited_q.pop_front();
          if (exp_r.status !== out_data_i.status || exp_r.start_slot !== out_data_i.start_slot
              || exp_r.slot_count !== out_data_i.slot_count) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) awaited_q.push_back(allocate_or_release(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_IDX_POLICY) policy = pol_e'(cfg_data_i[1:0]);
        else region_reg = cfg_data_i;
      end
    end
  end
endmodule

/* verif/contiguous_slot_allocator_core_test.sv */
`timescale 1ns / 1ps

module contiguous_slot_allocator_core_test;
  import csa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  int fail_count, pending, result_count;
  bit hold_rx = 0;
  int rx_gap = 0;
  int sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  contiguous_slot_allocator_core uut (.*);

  contiguous_slot_allocator_core_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  task automatic send_item(logic k, logic [7:0] own, logic [6:0] sz);
    int gap;
    gap = $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{kind: k, owner_id: own, request_size: sz};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [6:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item(int region_hint);
    int r;
    logic [6:0] sz;
    r = $urandom_range(0, 99);
    if (r < 3) sz = 7'($urandom_range(0, 127));
    else if (r < 15) sz = 7'($urandom_range(1, 64));
    else sz = 7'($urandom_range(1, (region_hint < 12) ? region_hint : 12));
    if ($urandom_range(0, 99) < 3)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), sz);
    else send_item($urandom_range(0, 99) < 35, 8'($urandom_range(1, 12)), sz);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) rx_gap = $urandom_range(0, 16);
    if (hold_rx) begin
      out_ready_i <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    int regions [6];
    regions = '{64, 1, 13, 32, 100, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(KIND_ALLOC, 8'd1, 7'd0);
    send_item(KIND_ALLOC, 8'd0, 7'd4);
    send_item(KIND_ALLOC, 8'd255, 7'd65);
    send_item(KIND_ALLOC, 8'd255, 7'd127);
    send_item(KIND_ALLOC, 8'd255, 7'd64);
    send_item(KIND_ALLOC, 8'd2, 7'd1);
    send_item(KIND_RELEASE, 8'd255, 7'd127);
    send_item(KIND_RELEASE, 8'd0, 7'd0);
    send_item(KIND_RELEASE, 8'd77, 7'd0);
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_IDX_POLICY, 7'(p) | 7'h7c);
      send_item(KIND_ALLOC, 8'd3, 7'd5);
      send_item(KIND_ALLOC, 8'd4, 7'd3);
      send_item(KIND_RELEASE, 8'd3, 7'd0);
      send_item(KIND_ALLOC, 8'd5, 7'd2);
    end
    write_reg(CFG_IDX_SLOTS, 7'd0);
    send_item(KIND_ALLOC, 8'd6, 7'd1);
    send_item(KIND_RELEASE, 8'd4, 7'd0);
    write_reg(CFG_IDX_SLOTS, 7'd64);
    fork
      begin
        hold_rx = 1;
        repeat (600) @(posedge clk_i);
        hold_rx = 0;
      end
      begin
        for (int i = 0; i < 8; i++) random_item(64);
        drain();
      end
    join
    for (int ph = 0; ph < 24; ph++) begin
      write_reg(CFG_IDX_POLICY, 7'($urandom_range(0, 127)));
      write_reg(CFG_IDX_SLOTS, 7'(regions[ph % 6]));
      for (int i = 0; i < 55; i++) random_item((regions[ph % 6] == 0) ? 1 :
                                               (regions[ph % 6] > 64 ? 64 : regions[ph % 6]));
    end
    drain();
    $display("%0d items over four policies and six region sizes, %0d results checked",
             sent, result_count);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/csa_pkg.sv
rtl/core/csa_cell.sv
rtl/core/csa_scan.sv
rtl/core/contiguous_slot_allocator_core.sv
verif/contiguous_slot_allocator_core_checker.sv
verif/contiguous_slot_allocator_core_test.sv
